// ===== rtl/uvs_pkg.sv =====
package uvs_pkg;

  // fixed-point format and count limits
  localparam int FRAC_BITS     = 15;
  localparam int MAX_DIVISIONS = 1024;
  localparam int CNT_W         = 11;
  localparam int OUT_W         = 16;

  // long division: fraction bits per lane (lane 0 slice/theta, lane 1 stack/phi)
  localparam int DIV_BITS   = 32;
  localparam int PHI_BITS   = 31;
  localparam int Q_W        = DIV_BITS + 1;

  // Q30 constants
  localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
  localparam logic [29:0] HALF_Q30 = 30'h2000_0000;
  localparam logic [31:0] PI_Q30   = 32'd3373259426;

  // Horner series: 6 steps, 3 stages each (product, reciprocal, correction)
  localparam int H_STEPS = 6;

  // global stage numbers
  localparam int ST_ANG  = DIV_BITS + 1;
  localparam int ST_FOLD = ST_ANG + 1;
  localparam int ST_PI   = ST_FOLD + 1;
  localparam int ST_SQ   = ST_PI + 1;
  localparam int ST_H0   = ST_SQ + 1;
  localparam int ST_SWAP = ST_H0 + 3 * H_STEPS;
  localparam int ST_MUL  = ST_SWAP + 1;

  // series divisors; the last sine step is a plain product and uses no entry
  localparam logic [7:0] COS_K [H_STEPS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
  localparam logic [7:0] SIN_K [H_STEPS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6, 8'd1};

  // reciprocals floor(2^32 / k)
  localparam logic [31:0] COS_M [H_STEPS] = '{
    32'(64'h1_0000_0000 / 132), 32'(64'h1_0000_0000 / 90), 32'(64'h1_0000_0000 / 56),
    32'(64'h1_0000_0000 / 30),  32'(64'h1_0000_0000 / 12), 32'(64'h1_0000_0000 / 2)};
  localparam logic [31:0] SIN_M [H_STEPS] = '{
    32'(64'h1_0000_0000 / 110), 32'(64'h1_0000_0000 / 72), 32'(64'h1_0000_0000 / 42),
    32'(64'h1_0000_0000 / 20),  32'(64'h1_0000_0000 / 6),  32'd0};

  // register map
  typedef enum logic {
    REG_STACK_COUNT = 1'b0,
    REG_SLICE_COUNT = 1'b1
  } cfg_reg_t;

  // data that rides along the angle and series stages
  typedef struct packed {
    logic [OUT_W-1:0]   tex_u;
    logic [OUT_W-1:0]   tex_v;
    logic [1:0][1:0]    quad;
    logic [1:0]         fold;
    logic [1:0][29:0]   xr;
    logic [1:0][29:0]   x2;
  } side_t;

  // zero acts as one, above the bound acts as the bound
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] cnt);
    if (cnt == '0) return CNT_W'(1);
    if (cnt > CNT_W'(MAX_DIVISIONS)) return CNT_W'(MAX_DIVISIONS);
    return cnt;
  endfunction

  // rounding carry of a quotient: (rem + n/2) >= n
  function automatic logic rnd_bit(input logic [CNT_W-1:0] rem, input logic [CNT_W-1:0] n);
    return ({1'b0, rem} + {2'b0, n[CNT_W-1:1]}) >= {1'b0, n};
  endfunction

  // saturate a magnitude with sign into a signed output word
  function automatic logic [OUT_W-1:0] enc_signed(input logic [63:0] mag, input logic neg);
    logic [63:0] lim;
    logic [63:0] m;
    lim = 64'd1 << FRAC_BITS;
    if (neg) begin
      m = (mag > lim) ? lim : mag;
      return OUT_W'(64'd0 - m);
    end
    m = (mag > lim - 64'd1) ? lim - 64'd1 : mag;
    return OUT_W'(m);
  endfunction

endpackage

// ===== rtl/uv_sphere_vertex.sv =====
// The pipeline has one stage per register.
// Throughput: one vertex per cycle unless stalled; the 32-stage long divider, the
// fold and scale stages and the 18-stage sine/cosine series all take an item each
// cycle. The whole pipeline advances while the output register is empty or taken.
// Reset (rst_n low, synchronous) clears all valid bits and loads stack_count
// with 16 and slice_count with 32.
module uv_sphere_vertex (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [uvs_pkg::CNT_W-1:0]   in_stack_index,
  input  logic [uvs_pkg::CNT_W-1:0]   in_slice_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [uvs_pkg::OUT_W-1:0] out_pos_x,
  output logic signed [uvs_pkg::OUT_W-1:0] out_pos_y,
  output logic signed [uvs_pkg::OUT_W-1:0] out_pos_z,
  output logic [uvs_pkg::OUT_W-1:0]   out_tex_u,
  output logic [uvs_pkg::OUT_W-1:0]   out_tex_v,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import uvs_pkg::*;

  localparam int LANE_BITS [2] = '{DIV_BITS, PHI_BITS};

  logic [CNT_W-1:0] stack_cnt_r;
  logic [CNT_W-1:0] slice_cnt_r;
  logic [CNT_W-1:0] n [2];
  logic             adv;
  logic [ST_MUL:0]  v_r;

  // configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stack_cnt_r <= CNT_W'(16);
      slice_cnt_r <= CNT_W'(32);
    end else if (psel && penable && pwrite) begin
      case (cfg_reg_t'(paddr[2]))
        REG_STACK_COUNT: stack_cnt_r <= pwdata[CNT_W-1:0];
        REG_SLICE_COUNT: slice_cnt_r <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg_t'(paddr[2]))
      REG_STACK_COUNT: prdata = {(32-CNT_W)'(0), stack_cnt_r};
      REG_SLICE_COUNT: prdata = {(32-CNT_W)'(0), slice_cnt_r};
      default:         prdata = '0;
    endcase
  end

  assign n[0] = eff_count(slice_cnt_r);
  assign n[1] = eff_count(stack_cnt_r);

  // advance the whole pipeline while the output register can take a result
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv && rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v_r       <= {v_r[ST_MUL-1:0], in_valid};
      out_valid <= v_r[ST_MUL];
    end
  end

  // ---------------- long division: index / count, one bit a stage
  logic [CNT_W-1:0] dr_r [DIV_BITS+1][2];
  logic [Q_W-1:0]   dq_r [DIV_BITS+1][2];
  logic [OUT_W-1:0] tex_r [FRAC_BITS+1:DIV_BITS][2];

  logic [CNT_W-1:0] idx [2];
  logic [CNT_W-1:0] clmp [2];
  assign idx[0] = in_slice_index;
  assign idx[1] = in_stack_index;

  // clamp the index and take the integer part (0 or 1)
  for (genvar l = 0; l < 2; l++) begin : g_in
    assign clmp[l] = (idx[l] > n[l]) ? n[l] : idx[l];
    always_ff @(posedge clk) begin
      if (adv) begin
        dr_r[0][l] <= (clmp[l] == n[l]) ? '0 : clmp[l];
        dq_r[0][l] <= {(Q_W-1)'(0), clmp[l] == n[l]};
      end
    end
  end

  for (genvar j = 1; j <= DIV_BITS; j++) begin : g_div
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [CNT_W:0] r2;
      logic           ge;
      assign r2 = {dr_r[j-1][l], 1'b0};
      assign ge = r2 >= {1'b0, n[l]};
      if (j <= LANE_BITS[l]) begin : g_step
        always_ff @(posedge clk) begin
          if (adv) begin
            dr_r[j][l] <= ge ? CNT_W'(r2 - {1'b0, n[l]}) : r2[CNT_W-1:0];
            dq_r[j][l] <= {dq_r[j-1][l][Q_W-2:0], ge};
          end
        end
      end else begin : g_hold
        always_ff @(posedge clk) begin
          if (adv) begin
            dr_r[j][l] <= dr_r[j-1][l];
            dq_r[j][l] <= dq_r[j-1][l];
          end
        end
      end
      // texture coordinate: round the quotient with FRAC_BITS fraction bits
      if (j == FRAC_BITS + 1) begin : g_tex
        always_ff @(posedge clk) begin
          if (adv) tex_r[j][l] <= OUT_W'(dq_r[j-1][l][FRAC_BITS:0]
                                         + (FRAC_BITS+1)'(rnd_bit(dr_r[j-1][l], n[l])));
        end
      end else if (j > FRAC_BITS + 1) begin : g_texd
        always_ff @(posedge clk) begin
          if (adv) tex_r[j][l] <= tex_r[j-1][l];
        end
      end
    end
  end

  // ---------------- angles as fractions of a turn
  logic [31:0] ang_r [2];
  side_t       side_r [ST_ANG:ST_MUL];

  always_ff @(posedge clk) begin
    if (adv) begin
      ang_r[0] <= 32'(dq_r[DIV_BITS][0] + Q_W'(rnd_bit(dr_r[DIV_BITS][0], n[0])));
      ang_r[1] <= 32'(Q_W'(ONE_Q30) - (dq_r[DIV_BITS][1]
                                       + Q_W'(rnd_bit(dr_r[DIV_BITS][1], n[1]))));
      side_r[ST_ANG] <= '{tex_u: tex_r[DIV_BITS][0], tex_v: tex_r[DIV_BITS][1],
                          default: '0};
    end
  end

  // fold to an octant, scale to radians, square
  side_t fold_nxt, pi_nxt, sq_nxt;
  always_comb begin
    fold_nxt = side_r[ST_ANG];
    for (int a = 0; a < 2; a++) begin
      fold_nxt.quad[a] = ang_r[a][31:30];
      fold_nxt.fold[a] = ang_r[a][29:0] > HALF_Q30;
      fold_nxt.xr[a]   = fold_nxt.fold[a] ? 30'(ONE_Q30 - {1'b0, ang_r[a][29:0]})
                                          : ang_r[a][29:0];
    end
    pi_nxt = side_r[ST_FOLD];
    for (int a = 0; a < 2; a++) begin
      pi_nxt.xr[a] = 30'((64'(side_r[ST_FOLD].xr[a]) * 64'(PI_Q30) + 64'(ONE_Q30)) >> 31);
    end
    sq_nxt = side_r[ST_PI];
    for (int a = 0; a < 2; a++) begin
      sq_nxt.x2[a] = 30'((64'(side_r[ST_PI].xr[a]) * 64'(side_r[ST_PI].xr[a])) >> 30);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[ST_FOLD] <= fold_nxt;
      side_r[ST_PI]   <= pi_nxt;
      side_r[ST_SQ]   <= sq_nxt;
    end
  end

  for (genvar k = ST_H0; k <= ST_MUL; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (adv) side_r[k] <= side_r[k-1];
    end
  end

  // ---------------- sine and cosine series, lanes [angle][0 cos, 1 sin]
  logic [59:0] hp_r [H_STEPS][2][2];
  logic [29:0] hn_r [H_STEPS][2][2];
  logic [29:0] hq_r [H_STEPS][2][2];
  logic [30:0] ht_r [H_STEPS][2][2];

  for (genvar s = 0; s < H_STEPS; s++) begin : g_hs
    for (genvar a = 0; a < 2; a++) begin : g_ha
      for (genvar c = 0; c < 2; c++) begin : g_hc
        logic [30:0] t_in;
        if (s == 0) begin : g_t0
          assign t_in = ONE_Q30;
        end else begin : g_tn
          assign t_in = ht_r[s-1][a][c];
        end
        if (c == 1 && s == H_STEPS - 1) begin : g_last
          // final sine step: (X * t) >> 30
          always_ff @(posedge clk) begin
            if (adv) begin
              hp_r[s][a][c] <= 60'(64'(side_r[ST_H0+3*s-1].xr[a]) * 64'(t_in));
              hn_r[s][a][c] <= hp_r[s][a][c][59:30];
              ht_r[s][a][c] <= {1'b0, hn_r[s][a][c]};
            end
          end
        end else begin : g_step
          logic [7:0]  kd;
          logic [31:0] md;
          logic [37:0] rem;
          assign kd  = (c == 0) ? COS_K[s] : SIN_K[s];
          assign md  = (c == 0) ? COS_M[s] : SIN_M[s];
          assign rem = 38'(hn_r[s][a][c]) - 38'(hq_r[s][a][c]) * 38'(kd);
          // product, reciprocal estimate, correct and subtract from one
          always_ff @(posedge clk) begin
            if (adv) begin
              hp_r[s][a][c] <= 60'(64'(side_r[ST_H0+3*s-1].x2[a]) * 64'(t_in));
              hn_r[s][a][c] <= hp_r[s][a][c][59:30];
              hq_r[s][a][c] <= 30'((64'(hp_r[s][a][c][59:30]) * 64'(md)) >> 32);
              ht_r[s][a][c] <= ONE_Q30 - 31'(hq_r[s][a][c] + 30'(rem >= 38'(kd)));
            end
          end
        end
      end
    end
  end

  // ---------------- undo the fold and apply the quadrant
  logic [30:0] cm_r [2];
  logic [30:0] sm_r [2];
  logic        cn_r [2];
  logic        sn_r [2];

  for (genvar a = 0; a < 2; a++) begin : g_q
    logic [30:0] c0, s0;
    assign c0 = side_r[ST_SWAP-1].fold[a] ? ht_r[H_STEPS-1][a][1] : ht_r[H_STEPS-1][a][0];
    assign s0 = side_r[ST_SWAP-1].fold[a] ? ht_r[H_STEPS-1][a][0] : ht_r[H_STEPS-1][a][1];
    always_ff @(posedge clk) begin
      if (adv) begin
        case (side_r[ST_SWAP-1].quad[a])
          2'd0:    begin cm_r[a] <= c0; cn_r[a] <= 1'b0; sm_r[a] <= s0; sn_r[a] <= 1'b0; end
          2'd1:    begin cm_r[a] <= s0; cn_r[a] <= 1'b1; sm_r[a] <= c0; sn_r[a] <= 1'b0; end
          2'd2:    begin cm_r[a] <= c0; cn_r[a] <= 1'b1; sm_r[a] <= s0; sn_r[a] <= 1'b1; end
          default: begin cm_r[a] <= s0; cn_r[a] <= 1'b0; sm_r[a] <= c0; sn_r[a] <= 1'b1; end
        endcase
      end
    end
  end

  // ---------------- products: angle 0 is theta, angle 1 is phi
  logic [61:0] px_r, pz_r;
  logic [30:0] py_r;
  logic        xn_r, yn_r, zn_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r <= 62'(cm_r[1]) * 62'(cm_r[0]);
      pz_r <= 62'(cm_r[1]) * 62'(sm_r[0]);
      py_r <= sm_r[1];
      xn_r <= cn_r[1] ^ cn_r[0];
      zn_r <= cn_r[1] ^ sn_r[0];
      yn_r <= sn_r[1];
    end
  end

  // ---------------- round, saturate, output register
  always_ff @(posedge clk) begin
    if (adv) begin
      out_pos_x <= enc_signed((64'(px_r) + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS),
                              xn_r);
      out_pos_z <= enc_signed((64'(pz_r) + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS),
                              zn_r);
      out_pos_y <= enc_signed((64'(py_r) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS),
                              yn_r);
      out_tex_u <= side_r[ST_MUL].tex_u;
      out_tex_v <= side_r[ST_MUL].tex_v;
    end
  end

endmodule

// ===== rtl/uvs_chk.sv =====
module uvs_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [uvs_pkg::OUT_W-1:0]   out_pos_x,
  input logic [uvs_pkg::OUT_W-1:0]   out_pos_y,
  input logic [uvs_pkg::OUT_W-1:0]   out_pos_z,
  input logic [uvs_pkg::OUT_W-1:0]   out_tex_u,
  input logic [uvs_pkg::OUT_W-1:0]   out_tex_v
);
  import uvs_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pos_x) && $stable(out_pos_y)
                                && $stable(out_pos_z) && $stable(out_tex_u)
                                && $stable(out_tex_v))
    else $error("stalled result changed");

  // take input exactly when the pipeline advances
  a_ready: assert property (@(posedge clk)
    in_ready == (rst_n && (!out_valid || out_ready)))
    else $error("in_ready does not follow output stall");

  // drop all results on reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // the u texture coordinate never exceeds one
  a_tex_u: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_tex_u <= 16'h8000)
    else $error("tex_u above one");

  // northern hemisphere has non-negative y
  a_north: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tex_v < 16'h4000 |-> !out_pos_y[OUT_W-1])
    else $error("negative y in northern half");

endmodule

bind uv_sphere_vertex uvs_chk u_chk (.*);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import uvs_pkg::*;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic [15:0] u;
    logic [15:0] v;
  } vertex_t;

  typedef struct {
    logic [63:0] cmag;
    logic [63:0] smag;
    logic        cneg;
    logic        sneg;
  } unit_vec_t;

  typedef struct {
    int      stack;
    int      slice;
    bit      typed;
    vertex_t vert;
  } grid_row_t;

  localparam logic [63:0] ONE30 = 64'd1 << 30;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [10:0] in_stack_index;
  logic [10:0] in_slice_index;
  logic        out_valid;
  logic        out_ready;
  logic signed [15:0] out_pos_x;
  logic signed [15:0] out_pos_y;
  logic signed [15:0] out_pos_z;
  logic [15:0] out_tex_u;
  logic [15:0] out_tex_v;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  uv_sphere_vertex dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_stack_index(in_stack_index), .in_slice_index(in_slice_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .out_tex_u(out_tex_u), .out_tex_v(out_tex_v),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  vertex_t     vertex_q[$];
  logic [10:0] stack_reg;
  logic [10:0] slice_reg;
  int          errors;
  int          sent;
  int          received;
  int          idle_pct;
  int          stall_pct;

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // zero acts as one, above the bound acts as the bound
  function automatic logic [63:0] divisions(input logic [10:0] r);
    if (r == 0) return 64'd1;
    if (r > 11'd1024) return 64'd1024;
    return {53'd0, r};
  endfunction

  // Horner series for sine and cosine of a Q30 radian value
  function automatic void series(input logic [63:0] xr, output logic [63:0] s,
                                 output logic [63:0] c);
    logic [63:0] x2;
    logic [63:0] t;
    x2 = (xr * xr) >> 30;
    t = ONE30;
    for (int i = 0; i < 5; i++) t = ONE30 - ((x2 * t) >> 30) / {56'd0, SIN_K[i]};
    s = (xr * t) >> 30;
    t = ONE30;
    for (int i = 0; i < 6; i++) t = ONE30 - ((x2 * t) >> 30) / {56'd0, COS_K[i]};
    c = t;
  endfunction

  // cosine and sine of an angle held as a fraction of a full turn
  function automatic unit_vec_t turn_trig(input logic [31:0] a);
    unit_vec_t   r;
    logic [63:0] rem;
    logic [63:0] x;
    logic [63:0] s0;
    logic [63:0] c0;
    logic [63:0] sw;
    logic        fold;
    rem = {34'd0, a[29:0]};
    fold = rem > (64'd1 << 29);
    x = fold ? ONE30 - rem : rem;
    series((x * 64'd3373259426 + ONE30) >> 31, s0, c0);
    if (fold) begin
      sw = s0; s0 = c0; c0 = sw;
    end
    case (a[31:30])
      2'd0: r = '{c0, s0, 1'b0, 1'b0};
      2'd1: r = '{s0, c0, 1'b1, 1'b0};
      2'd2: r = '{c0, s0, 1'b1, 1'b1};
      default: r = '{s0, c0, 1'b0, 1'b1};
    endcase
    return r;
  endfunction

  function automatic logic [15:0] sat_q15(input logic [63:0] mag, input logic neg);
    if (neg) return 16'(64'd0 - ((mag > 64'd32768) ? 64'd32768 : mag));
    return 16'((mag > 64'd32767) ? 64'd32767 : mag);
  endfunction

  function automatic logic [63:0] rnd(input logic [63:0] v, input int s);
    return (v + (64'd1 << (s - 1))) >> s;
  endfunction

  function automatic vertex_t sphere_point(input logic [10:0] stk, input logic [10:0] slc);
    vertex_t     o;
    logic [63:0] ns;
    logic [63:0] nl;
    logic [63:0] st;
    logic [63:0] sl;
    logic [31:0] theta;
    logic [31:0] phi;
    unit_vec_t   p;
    unit_vec_t   t;
    ns = divisions(stack_reg);
    nl = divisions(slice_reg);
    st = (stk > ns) ? ns : {53'd0, stk};
    sl = (slc > nl) ? nl : {53'd0, slc};
    theta = 32'(((sl << 32) + nl / 2) / nl);
    phi = 32'(ONE30 - ((st << 31) + ns / 2) / ns);
    p = turn_trig(phi);
    t = turn_trig(theta);
    o.x = sat_q15(rnd(p.cmag * t.cmag, 45), p.cneg != t.cneg);
    o.y = sat_q15(rnd(p.smag, 15), p.sneg);
    o.z = sat_q15(rnd(p.cmag * t.smag, 45), p.cneg != t.sneg);
    o.u = 16'(((sl << 15) + nl / 2) / nl);
    o.v = 16'(((st << 15) + ns / 2) / ns);
    return o;
  endfunction

  // drive one grid point, hold until transfer, then maybe idle
  task automatic send_point(input int stk, input int slc, input bit typed, input vertex_t v);
    in_valid <= 1'b1;
    in_stack_index <= 11'(stk);
    in_slice_index <= 11'(slc);
    do @(posedge clk); while (!in_ready);
    vertex_q.push_back(typed ? v : sphere_point(11'(stk), 11'(slc)));
    sent++;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic reg_write(input cfg_reg_t r, input logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {r, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (r == REG_STACK_COUNT) stack_reg = val[10:0];
    else slice_reg = val[10:0];
  endtask

  // receiver backpressure
  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  // compare each result transfer against the oldest expectation
  always @(posedge clk) begin
    vertex_t e;
    vertex_t a;
    if (rst_n && out_valid && out_ready) begin
      a = '{out_pos_x, out_pos_y, out_pos_z, out_tex_u, out_tex_v};
      received++;
      if (vertex_q.size() == 0) begin
        $display("%0t: unexpected vertex x=%0d y=%0d z=%0d u=%0d v=%0d", $time,
                 $signed(a.x), $signed(a.y), $signed(a.z), a.u, a.v);
        errors++;
      end else begin
        e = vertex_q.pop_front();
        if (e !== a) begin
          $display("%0t: vertex mismatch exp x=%0d y=%0d z=%0d u=%0d v=%0d", $time,
                   $signed(e.x), $signed(e.y), $signed(e.z), e.u, e.v);
          $display("%0t:                 act x=%0d y=%0d z=%0d u=%0d v=%0d", $time,
                   $signed(a.x), $signed(a.y), $signed(a.z), a.u, a.v);
          errors++;
        end
      end
    end
  end

  // watchdog
  initial begin
    #10ms;
    $display("timeout with %0d vertices pending", vertex_q.size());
    $display("FAILURE");
    $finish;
  end

  initial begin
    grid_row_t rows[$];
    int        ns;
    int        nl;
    int        pick;
    int        stk;
    int        slc;
    int        ph_idle;
    int        ph_stall;
    logic [10:0] cfg_set[6][2];
    errors = 0;
    sent = 0;
    received = 0;
    idle_pct = 0;
    stall_pct = 0;
    stack_reg = 11'd16;
    slice_reg = 11'd32;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_stack_index = '0;
    in_slice_index = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed grid points at the reset counts (16 stacks, 32 slices)
    rows.push_back('{0, 0, 1, '{16'd0, 16'd32767, 16'd0, 16'd0, 16'd0}});
    rows.push_back('{16, 0, 1, '{16'd0, 16'h8000, 16'd0, 16'd0, 16'h8000}});
    rows.push_back('{8, 0, 1, '{16'd32767, 16'd0, 16'd0, 16'd0, 16'h4000}});
    rows.push_back('{8, 32, 1, '{16'd32767, 16'd0, 16'd0, 16'h8000, 16'h4000}});
    rows.push_back('{8, 8, 0, '{default: '0}});
    rows.push_back('{8, 16, 0, '{default: '0}});
    rows.push_back('{8, 24, 0, '{default: '0}});
    rows.push_back('{4, 4, 0, '{default: '0}});
    rows.push_back('{12, 20, 0, '{default: '0}});
    rows.push_back('{1, 1, 0, '{default: '0}});
    rows.push_back('{15, 31, 0, '{default: '0}});
    rows.push_back('{1024, 1024, 0, '{default: '0}});
    rows.push_back('{2047, 2047, 0, '{default: '0}});
    rows.push_back('{17, 33, 0, '{default: '0}});
    rows.push_back('{1365, 682, 0, '{default: '0}});
    rows.push_back('{682, 1365, 0, '{default: '0}});
    foreach (rows[i]) send_point(rows[i].stack, rows[i].slice, rows[i].typed, rows[i].vert);
    drain();

    // count settings per phase: extremes, zero, above the bound, odd sizes
    cfg_set = '{'{11'd1, 11'd1}, '{11'd1024, 11'd1024}, '{11'd0, 11'd2047},
                '{11'd2047, 11'd0}, '{11'd3, 11'd7}, '{11'd0, 11'd0}};
    for (int ph = 0; ph < 6; ph++) begin
      reg_write(REG_STACK_COUNT, (ph == 5) ? $urandom_range(2, 1023) | 32'hFFFF_F800
                                           : {21'h1FFFFF, cfg_set[ph][0]});
      reg_write(REG_SLICE_COUNT, (ph == 5) ? $urandom_range(2, 1023) : {21'd0, cfg_set[ph][1]});
      case (ph % 4)
        0: begin ph_idle = 0;  ph_stall = 0;  end
        1: begin ph_idle = 68; ph_stall = 0;  end
        2: begin ph_idle = 0;  ph_stall = 68; end
        default: begin ph_idle = 33; ph_stall = 33; end
      endcase
      idle_pct = ph_idle;
      stall_pct = ph_stall;
      ns = int'(divisions(stack_reg));
      nl = int'(divisions(slice_reg));
      for (int n = 0; n < 125; n++) begin
        // mostly on-grid points, some poles and seams, some out of range
        pick = $urandom_range(9);
        if (pick < 7) begin
          stk = $urandom_range(ns);
          slc = $urandom_range(nl);
        end else if (pick == 7) begin
          stk = $urandom_range(1) ? ns : 0;
          slc = $urandom_range(1) ? nl : 0;
        end else begin
          stk = $urandom_range(2047);
          slc = $urandom_range(2047);
        end
        // stretch with no idling or stalls in the middle of each phase
        if (n == 50) begin
          idle_pct = 0;
          stall_pct = 0;
        end else if (n == 75) begin
          idle_pct = ph_idle;
          stall_pct = ph_stall;
        end
        send_point(stk, slc, 1'b0, '{default: '0});
      end
      drain();
    end

    $display("sent %0d grid points over 7 count settings, %0d vertices checked", sent,
             received);
    $display("covered poles, equator, seams, clamped indices and degenerate counts");
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
